/* hdl/hts_pkg.sv */
// Shared types and constants for the HTML markup stripper.
// Beat structs, character codes and keyword strings; no dependencies.
package hts_pkg;

    localparam int COUNT_WIDTH = 16;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [47:0] OPEN_SCRIPT  = "script";
    localparam logic [39:0] OPEN_STYLE   = "style";
    localparam logic [23:0] OPEN_COMMENT = "!--";

    localparam logic [71:0] CLOSE_SCRIPT  = "</script>";
    localparam logic [63:0] CLOSE_STYLE   = "</style>";
    localparam logic [23:0] CLOSE_COMMENT = "-->";

    typedef struct packed {
        logic [7:0] in_char;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]  out_char;
        logic        end_of_text;
        logic [15:0] kept_count;
    } t_out_beat;

    typedef struct packed {
        logic      byte_v;
        t_out_beat byte_beat;
        logic      end_v;
        t_out_beat end_beat;
    } t_push;

    function automatic logic [15:0] kept_sat(input logic [COUNT_WIDTH-1:0] cnt);
        logic [COUNT_WIDTH+15:0] w;
        w = {16'b0, cnt};
        if (w[COUNT_WIDTH+15:16] != '0) begin
            return 16'hFFFF;
        end
        return w[15:0];
    endfunction

endpackage

/* hdl/hts_scan.sv */
// Input register and per-byte scan logic of the HTML markup stripper.
// Depends on hts_pkg; feeds up to two result beats to hts_outq.
module hts_scan (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  hts_pkg::t_in_beat i_data,
    input  logic [1:0]      i_room,
    output hts_pkg::t_push  o_push
);

    typedef enum logic [1:0] {
        MODE_TEXT   = 2'd0,
        MODE_TAG    = 2'd1,
        MODE_ENTITY = 2'd2,
        MODE_SKIP   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_SCRIPT  = 2'd0,
        KIND_STYLE   = 2'd1,
        KIND_COMMENT = 2'd2,
        KIND_SPARE   = 2'd3
    } t_kind;

    logic                            r_in_valid;
    hts_pkg::t_in_beat               r_in;
    t_mode                           r_mode,  n_mode;
    logic [2:0]                      r_len,   n_len;
    logic [47:0]                     r_pre,   n_pre;
    t_kind                           r_kind,  n_kind;
    logic [71:0]                     r_tail,  n_tail;
    logic [3:0]                      r_fill,  n_fill;
    logic [hts_pkg::COUNT_WIDTH-1:0] r_count, n_count;

    logic        emit;
    logic [7:0]  emit_ch;
    logic        close_hit;
    logic [1:0]  push_cnt;
    logic        fire;
    logic [7:0]  c;
    logic [71:0] shift_tail;
    logic [3:0]  shift_fill;

    assign c          = r_in.in_char;
    assign push_cnt   = {1'b0, emit} + {1'b0, r_in.last_byte};
    assign fire       = r_in_valid && (push_cnt <= i_room);
    assign o_stall    = r_in_valid && !fire;
    assign shift_tail = {r_tail[63:0], c};
    assign shift_fill = (r_fill < 4'd9) ? r_fill + 4'd1 : 4'd9;

    always_comb begin
        unique case (r_kind)
            KIND_SCRIPT: close_hit = (shift_fill >= 4'd9) &&
                                     (shift_tail == hts_pkg::CLOSE_SCRIPT);
            KIND_STYLE:  close_hit = (shift_fill >= 4'd8) &&
                                     (shift_tail[63:0] == hts_pkg::CLOSE_STYLE);
            default:     close_hit = (shift_fill >= 4'd3) &&
                                     (shift_tail[23:0] == hts_pkg::CLOSE_COMMENT);
        endcase
    end

    always_comb begin
        n_mode  = r_mode;
        n_len   = r_len;
        n_pre   = r_pre;
        n_kind  = r_kind;
        n_tail  = r_tail;
        n_fill  = r_fill;
        n_count = r_count;
        emit    = 1'b0;
        emit_ch = c;

        unique case (r_mode)
            MODE_TEXT: begin
                if (c == hts_pkg::CH_LT) begin
                    n_mode = MODE_TAG;
                    n_len  = 3'd0;
                end else if (c == hts_pkg::CH_AMP) begin
                    n_mode = MODE_ENTITY;
                end else begin
                    emit = 1'b1;
                end
            end
            MODE_TAG: begin
                if (r_len < 3'd6) begin
                    for (int k = 0; k < 6; k++) begin
                        if (r_len == 3'(k)) begin
                            n_pre[47-8*k -: 8] = c;
                        end
                    end
                    n_len = r_len + 3'd1;
                end else begin
                    n_len = 3'd7;
                end
                if (n_len == 3'd6 && n_pre == hts_pkg::OPEN_SCRIPT) begin
                    n_mode = MODE_SKIP;
                    n_kind = KIND_SCRIPT;
                    n_len  = 3'd0;
                    n_fill = 4'd0;
                end else if (n_len == 3'd5 && n_pre[47:8] == hts_pkg::OPEN_STYLE) begin
                    n_mode = MODE_SKIP;
                    n_kind = KIND_STYLE;
                    n_len  = 3'd0;
                    n_fill = 4'd0;
                end else if (n_len == 3'd3 && n_pre[47:24] == hts_pkg::OPEN_COMMENT) begin
                    n_mode = MODE_SKIP;
                    n_kind = KIND_COMMENT;
                    n_len  = 3'd0;
                    n_fill = 4'd0;
                end
                if (c == hts_pkg::CH_GT) begin
                    emit    = 1'b1;
                    emit_ch = hts_pkg::CH_SPACE;
                    n_mode  = MODE_TEXT;
                end
            end
            MODE_ENTITY: begin
                if (c == hts_pkg::CH_SEMI) begin
                    emit    = 1'b1;
                    emit_ch = hts_pkg::CH_SPACE;
                    n_mode  = MODE_TEXT;
                end
            end
            MODE_SKIP: begin
                n_tail = shift_tail;
                n_fill = shift_fill;
                if (close_hit) begin
                    n_mode = MODE_TEXT;
                    n_fill = 4'd0;
                end
            end
            default: ;
        endcase

        if (emit && r_count != '1) begin
            n_count = r_count + 1'b1;
        end
    end

    always_comb begin
        o_push                      = '0;
        o_push.byte_v               = fire && emit;
        o_push.byte_beat.out_char   = emit_ch;
        o_push.end_v                = fire && r_in.last_byte;
        o_push.end_beat.end_of_text = 1'b1;
        o_push.end_beat.kept_count  = hts_pkg::kept_sat(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= MODE_TEXT;
            r_len      <= 3'd0;
            r_kind     <= KIND_SCRIPT;
            r_fill     <= 4'd0;
            r_count    <= '0;
        end else begin
            if (!r_in_valid || fire) begin
                r_in_valid <= i_valid;
            end
            if (fire) begin
                if (r_in.last_byte) begin
                    r_mode  <= MODE_TEXT;
                    r_len   <= 3'd0;
                    r_kind  <= KIND_SCRIPT;
                    r_fill  <= 4'd0;
                    r_count <= '0;
                end else begin
                    r_mode  <= n_mode;
                    r_len   <= n_len;
                    r_kind  <= n_kind;
                    r_fill  <= n_fill;
                    r_count <= n_count;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_in_valid || fire) begin
            r_in <= i_data;
        end
        if (fire) begin
            r_pre  <= n_pre;
            r_tail <= n_tail;
        end
    end

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in.last_byte) |=> (r_mode == MODE_TEXT && r_count == '0 && r_fill == 4'd0))
        else $error("state not cleared after end of text");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 4'd9)
        else $error("tail fill out of range");

    a_kind_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kind != KIND_SPARE)
        else $error("unused skip kind reached");

    a_skip_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_mode == MODE_SKIP) |-> !emit)
        else $error("byte emitted inside skipped block");

endmodule

/* hdl/hts_outq.sv */
// Two-slot result queue: takes up to two beats per cycle, presents one.
// Depends on hts_pkg; o_room tells hts_scan how many beats fit this cycle.
module hts_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hts_pkg::t_push     i_push,
    input  logic               i_stall,
    output logic [1:0]         o_room,
    output logic               o_valid,
    output hts_pkg::t_out_beat o_data
);

    logic [1:0]         r_cnt,  n_cnt;
    hts_pkg::t_out_beat r_slot0, n_slot0;
    hts_pkg::t_out_beat r_slot1, n_slot1;
    logic               pop;

    assign pop     = (r_cnt != 2'd0) && !i_stall;
    assign o_room  = 2'd2 - r_cnt + {1'b0, pop};
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_slot0;

    always_comb begin
        n_cnt   = r_cnt;
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        if (pop) begin
            n_slot0 = r_slot1;
            n_cnt   = r_cnt - 2'd1;
        end
        if (i_push.byte_v) begin
            if (n_cnt == 2'd0) begin
                n_slot0 = i_push.byte_beat;
            end else begin
                n_slot1 = i_push.byte_beat;
            end
            n_cnt = n_cnt + 2'd1;
        end
        if (i_push.end_v) begin
            if (n_cnt == 2'd0) begin
                n_slot0 = i_push.end_beat;
            end else begin
                n_slot1 = i_push.end_beat;
            end
            n_cnt = n_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("result queue overfilled");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, i_push.byte_v} + {1'b0, i_push.end_v}) <= o_room)
        else $error("push beyond free slots");

    a_end_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.end_of_text) |-> (o_data.out_char == 8'd0))
        else $error("end beat carries a character");

    a_byte_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.end_of_text) |-> (o_data.kept_count == 16'd0))
        else $error("byte beat carries a count");

endmodule

/* hdl/html_tag_stripper_core.sv */
// Top level of the HTML markup stripper: scan stage plus result queue.
// Depends on hts_pkg, hts_scan and hts_outq.
//
//   port group   direction  beat          handshake
//   i_data       in         t_in_beat     i_valid / o_stall
//   o_data       out        t_out_beat    o_valid / i_stall
//
// One byte per cycle while not stalled; an accepted byte is registered at the input,
// then in a result queue slot. A last byte that also emits gives two result beats.
// The two-slot result queue sets the rate: input stalls only when its free slots
// fall short of the beats the registered byte produces.
// Reset is synchronous, active low, and returns the block to text mode.
module html_tag_stripper_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  hts_pkg::t_in_beat  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output hts_pkg::t_out_beat o_data
);

    hts_pkg::t_push push;
    logic [1:0]     room;

    hts_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .i_room  (room),
        .o_push  (push)
    );

    hts_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_stall (i_stall),
        .o_room  (room),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

endmodule

/* verif/testbench.sv */
// Self-checking testbench for html_tag_stripper_core: streams bytes under random idling
// and back-pressure, predicts each output beat and compares field by field.
// Depends on hts_pkg and html_tag_stripper_core.
module testbench;

    localparam int CLK_PERIOD = 4;
    localparam longint unsigned KEPT_MAX = (64'd1 << hts_pkg::COUNT_WIDTH) - 1;

    typedef enum logic [1:0] {SCAN_TEXT, SCAN_TAG, SCAN_ENTITY, SCAN_SKIP} t_scan_mode;
    typedef enum logic [1:0] {SKIP_SCRIPT, SKIP_STYLE, SKIP_COMMENT, SKIP_SPARE} t_skip_sel;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    hts_pkg::t_in_beat  in_data = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    hts_pkg::t_out_beat out_data;

    logic      stall_hold = 1'b0;
    int        stall_pct = 0;
    int        idle_pct = 0;
    int        error_count = 0;

    t_scan_mode      scan_mode;
    logic [2:0]      tag_len;
    logic [7:0]      tag_text [0:5];
    t_skip_sel       skip_sel;
    logic [7:0]      tail_win [0:8];
    logic [3:0]      tail_cnt;
    longint unsigned kept_total;

    hts_pkg::t_out_beat stripped_beats [$];
    logic [7:0]         doc_bytes [$];

    html_tag_stripper_core u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_stall (in_stall),
        .i_data  (in_data),
        .o_valid (out_valid),
        .i_stall (out_stall),
        .o_data  (out_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic void log_error(input string msg);
        error_count++;
        if (error_count <= 10) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endfunction

    function automatic void clear_strip_state();
        scan_mode = SCAN_TEXT;
        tag_len = '0;
        foreach (tag_text[i]) tag_text[i] = '0;
        skip_sel = SKIP_SCRIPT;
        foreach (tail_win[i]) tail_win[i] = '0;
        tail_cnt = '0;
        kept_total = 0;
    endfunction

    function automatic logic tag_text_is(input logic [71:0] word, input int len);
        if (tag_len != len) return 1'b0;
        for (int i = 0; i < len; i++) begin
            if (tag_text[i] != word[8*(len-1-i) +: 8]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic tail_ends_with(input logic [71:0] word, input int len);
        if (tail_cnt < len) return 1'b0;
        for (int i = 0; i < len; i++) begin
            if (tail_win[9-len+i] != word[8*(len-1-i) +: 8]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void enter_skip(input t_skip_sel sel);
        scan_mode = SCAN_SKIP;
        skip_sel = sel;
        tag_len = '0;
        tail_cnt = '0;
    endfunction

    function automatic void strip_byte(input hts_pkg::t_in_beat beat);
        logic [7:0]         c;
        logic [7:0]         ch;
        logic               emit;
        logic               closed;
        hts_pkg::t_out_beat res;
        c = beat.in_char;
        ch = 8'h00;
        emit = 1'b0;
        case (scan_mode)
            SCAN_TEXT: begin
                if (c == hts_pkg::CH_LT) begin
                    scan_mode = SCAN_TAG;
                    tag_len = '0;
                end else if (c == hts_pkg::CH_AMP) begin
                    scan_mode = SCAN_ENTITY;
                end else begin
                    emit = 1'b1;
                    ch = c;
                end
            end
            SCAN_TAG: begin
                if (tag_len < 6) begin
                    tag_text[tag_len] = c;
                    tag_len++;
                end else begin
                    tag_len = 3'd7;
                end
                if (tag_text_is(hts_pkg::OPEN_SCRIPT, $bits(hts_pkg::OPEN_SCRIPT) / 8)) begin
                    enter_skip(SKIP_SCRIPT);
                end else if (tag_text_is(hts_pkg::OPEN_STYLE,
                                         $bits(hts_pkg::OPEN_STYLE) / 8)) begin
                    enter_skip(SKIP_STYLE);
                end else if (tag_text_is(hts_pkg::OPEN_COMMENT,
                                         $bits(hts_pkg::OPEN_COMMENT) / 8)) begin
                    enter_skip(SKIP_COMMENT);
                end
                if (c == hts_pkg::CH_GT) begin
                    emit = 1'b1;
                    ch = hts_pkg::CH_SPACE;
                    scan_mode = SCAN_TEXT;
                end
            end
            SCAN_ENTITY: begin
                if (c == hts_pkg::CH_SEMI) begin
                    emit = 1'b1;
                    ch = hts_pkg::CH_SPACE;
                    scan_mode = SCAN_TEXT;
                end
            end
            default: begin
                for (int i = 0; i < 8; i++) tail_win[i] = tail_win[i+1];
                tail_win[8] = c;
                if (tail_cnt < 9) tail_cnt++;
                case (skip_sel)
                    SKIP_SCRIPT: closed = tail_ends_with(hts_pkg::CLOSE_SCRIPT,
                                                         $bits(hts_pkg::CLOSE_SCRIPT) / 8);
                    SKIP_STYLE:  closed = tail_ends_with(hts_pkg::CLOSE_STYLE,
                                                         $bits(hts_pkg::CLOSE_STYLE) / 8);
                    default: closed = tail_ends_with(hts_pkg::CLOSE_COMMENT,
                                                     $bits(hts_pkg::CLOSE_COMMENT) / 8);
                endcase
                if (closed) begin
                    scan_mode = SCAN_TEXT;
                    tail_cnt = '0;
                end
            end
        endcase
        if (emit) begin
            if (kept_total < KEPT_MAX) kept_total++;
            res.out_char = ch;
            res.end_of_text = 1'b0;
            res.kept_count = 16'h0000;
            stripped_beats.push_back(res);
        end
        if (beat.last_byte) begin
            res.out_char = 8'h00;
            res.end_of_text = 1'b1;
            res.kept_count = (kept_total > 64'hFFFF) ? 16'hFFFF : kept_total[15:0];
            stripped_beats.push_back(res);
            clear_strip_state();
        end
    endfunction

    task automatic check_beat(input hts_pkg::t_out_beat got);
        hts_pkg::t_out_beat want;
        if (stripped_beats.size() == 0) begin
            log_error($sformatf("unexpected beat: char %02h end %0b count %0d",
                                got.out_char, got.end_of_text, got.kept_count));
            return;
        end
        want = stripped_beats.pop_front();
        if (got.out_char !== want.out_char || got.end_of_text !== want.end_of_text ||
            got.kept_count !== want.kept_count) begin
            log_error($sformatf({"expected char %02h end %0b count %0d, ",
                                 "got char %02h end %0b count %0d"},
                                want.out_char, want.end_of_text, want.kept_count,
                                got.out_char, got.end_of_text, got.kept_count));
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) check_beat(out_data);
        out_stall <= stall_hold || ($urandom_range(0, 99) < stall_pct);
    end

    task automatic feed_byte(input logic [7:0] ch, input logic last);
        hts_pkg::t_in_beat beat;
        beat.in_char = ch;
        beat.last_byte = last;
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= beat;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        strip_byte(beat);
    endtask

    task automatic feed_doc();
        foreach (doc_bytes[i]) feed_byte(doc_bytes[i], i == doc_bytes.size() - 1);
    endtask

    task automatic wait_drained();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (stripped_beats.size() != 0 && waited < 5000) begin
            @(posedge clk);
            waited++;
        end
        if (stripped_beats.size() != 0) begin
            log_error($sformatf("%0d beats never arrived", stripped_beats.size()));
            stripped_beats.delete();
        end
        repeat (8) @(posedge clk);
    endtask

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) doc_bytes.push_back(s[i]);
    endfunction

    function automatic logic [7:0] text_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (c == hts_pkg::CH_LT || c == hts_pkg::CH_AMP) c = "a";
        return c;
    endfunction

    function automatic logic [7:0] tag_char();
        logic [7:0] c;
        string      pick;
        pick = "scriptyle!-/";
        if ($urandom_range(0, 1)) begin
            c = pick[$urandom_range(0, pick.len() - 1)];
        end else begin
            c = 8'($urandom_range(0, 255));
        end
        if (c == hts_pkg::CH_GT) c = "x";
        return c;
    endfunction

    function automatic void add_segment();
        string open_s;
        string close_s;
        int    kind;
        logic [7:0] c;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2: begin
                repeat ($urandom_range(1, 6)) doc_bytes.push_back(text_char());
            end
            3: begin
                doc_bytes.push_back(hts_pkg::CH_LT);
                repeat ($urandom_range(0, 8)) doc_bytes.push_back(tag_char());
                doc_bytes.push_back(hts_pkg::CH_GT);
            end
            4: begin
                doc_bytes.push_back(hts_pkg::CH_AMP);
                repeat ($urandom_range(0, 4)) begin
                    c = 8'($urandom_range(0, 255));
                    if (c == hts_pkg::CH_SEMI) c = "q";
                    doc_bytes.push_back(c);
                end
                doc_bytes.push_back(hts_pkg::CH_SEMI);
            end
            5, 6, 7: begin
                case (kind)
                    5: begin
                        open_s = "<script";
                        close_s = "</script>";
                    end
                    6: begin
                        open_s = "<style";
                        close_s = "</style>";
                    end
                    default: begin
                        open_s = "<!--";
                        close_s = "-->";
                    end
                endcase
                add_text(open_s);
                if ($urandom_range(0, 1)) doc_bytes.push_back(hts_pkg::CH_GT);
                repeat ($urandom_range(0, 6)) begin
                    if ($urandom_range(0, 3) == 0) begin
                        add_text(close_s.substr(0, $urandom_range(0, close_s.len() - 2)));
                    end else begin
                        doc_bytes.push_back(8'($urandom_range(0, 255)));
                    end
                end
                add_text(close_s);
            end
            8: begin
                case ($urandom_range(0, 3))
                    0: add_text("<SCRIPT>");
                    1: add_text("<scrip>");
                    2: add_text("<!-x>");
                    default: add_text("<xstyle>");
                endcase
            end
            default: begin
                repeat ($urandom_range(1, 4)) doc_bytes.push_back(8'($urandom_range(0, 255)));
            end
        endcase
    endfunction

    task automatic run_phase(input int gap_pct, input int busy_pct, input int items);
        int sent;
        idle_pct = gap_pct;
        stall_pct <= busy_pct;
        sent = 0;
        while (sent < items) begin
            doc_bytes.delete();
            repeat ($urandom_range(1, 8)) add_segment();
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(0, doc_bytes.size() - 1)) void'(doc_bytes.pop_back());
            end
            feed_doc();
            sent += doc_bytes.size();
        end
        wait_drained();
    endtask

    task automatic test_directed_cases();
        idle_pct = 0;
        stall_pct <= 0;
        doc_bytes.delete();
        doc_bytes.push_back(8'h00);
        add_text("&;<xscript>");
        doc_bytes.push_back(8'hFF);
        feed_doc();
        doc_bytes.delete();
        add_text("<!--->-->");
        feed_doc();
        doc_bytes.delete();
        add_text("<style>");
        feed_doc();
        wait_drained();
    endtask

    task automatic test_random_traffic();
        run_phase(0, 0, 110);
        run_phase(57, 0, 110);
        run_phase(0, 57, 110);
        run_phase(38, 38, 110);
    endtask

    task automatic test_output_backpressure();
        idle_pct = 0;
        stall_pct <= 0;
        fork
            begin
                stall_hold <= 1'b1;
                repeat (60) @(posedge clk);
                stall_hold <= 1'b0;
            end
        join_none
        repeat (40) feed_byte(text_char(), 1'b0);
        wait_drained();
        repeat (10) feed_byte(text_char(), 1'b0);
        feed_byte(text_char(), 1'b1);
        wait_drained();
    endtask

    initial begin
        clear_strip_state();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_random_traffic();
        test_output_backpressure();
        if (error_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    initial begin
        #(CLK_PERIOD * 400000);
        $display("testbench NOT OK");
        $finish;
    end

endmodule
